// ===== sv/rpmc_pkg.sv =====
package rpmc_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int REF_BITS_DEF  = 16;
  localparam int PAGE_BITS_DEF = 36;
  localparam int WAITER_MAX    = 255;

  typedef enum logic [1:0] {
    OP_ACQUIRE  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_WAIT_END = 2'd2,
    OP_BAD      = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_HIT_IN_USE = 4'd0,
    ST_HIT_REACT  = 4'd1,
    ST_NEW_MAP    = 4'd2,
    ST_NONE_FREE  = 4'd3,
    ST_MUST_WAIT  = 4'd4,
    ST_HELD       = 4'd5,
    ST_FREED      = 4'd6,
    ST_BYPASS     = 4'd7,
    ST_ERROR      = 4'd8,
    ST_WAIT_ENDED = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_SCAN,
    FS_READ,
    FS_EXEC,
    FS_OUT
  } fsm_t;

  localparam logic CFG_DIRECT_MAP = 1'b0;
  localparam logic CFG_POOL_SIZE  = 1'b1;

endpackage

// ===== sv/refcounted_page_map_cache.sv =====
// Page map cache: a pool of up to SLOTS mapping slots, each holding a page tag and a
// reference count, with an LRU free list of idle slots. Acquire compares the page
// against every slot in the pool one slot per cycle through the tag memory. The slot
// tables live in one-read-port memories read in the cycle before the update. After
// reset and after each pool_size write, a clearing pass rebuilds the free list before
// items are accepted.
module refcounted_page_map_cache #(
  parameter int SLOTS     = rpmc_pkg::SLOTS_DEF,
  parameter int REF_BITS  = rpmc_pkg::REF_BITS_DEF,
  parameter int PAGE_BITS = rpmc_pkg::PAGE_BITS_DEF,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [PAGE_BITS-1:0] page_index,
  input  logic [5:0]           entry_index,
  input  logic                 may_wait,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           status,
  output logic [5:0]           slot,
  output logic                 replaced_valid,
  output logic [PAGE_BITS-1:0] replaced_page,
  output logic [REF_BITS-1:0]  refs_now,
  output logic                 wake_waiters,
  output logic [SW:0]          used_now,
  output logic [SW:0]          used_peak
);

  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  rpmc_pkg::fsm_t state, state_next;

  logic              direct_map;
  logic [6:0]        pool_size;
  logic [SW:0]       active;
  logic [REF_BITS-1:0] refs [SLOTS];
  logic [SW-1:0]     fnext [SLOTS];
  logic [SW-1:0]     fprev [SLOTS];
  logic [SW-1:0]     free_head, free_tail;
  logic [SW:0]       free_count, in_use, peak;
  logic [7:0]        waiters;
  logic [SW:0]       clr_idx;

  logic [1:0]           op_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [5:0]           entry_r;
  logic                 wait_r;

  logic [SW-1:0]        tgt;
  logic [REF_BITS-1:0]  rc_q;
  logic [SW-1:0]        nx_q, pv_q;
  logic                 scan_done, hit, tag_v;
  logic [SW-1:0]        hit_slot;
  logic [PAGE_BITS-1:0] tag_q;
  logic                 wr_tag;
  logic                 miss_r;

  logic [3:0]           o_status;
  logic [5:0]           o_slot;
  logic                 o_rv, o_wake;
  logic [PAGE_BITS-1:0] o_rp;
  logic [REF_BITS-1:0]  o_refs;

  assign active = (pool_size == 7'd0) ? (SW+1)'(1) :
                  ({25'd0, pool_size} > 32'(SLOTS)) ? (SW+1)'(SLOTS) : (SW+1)'(pool_size);

  assign cfg_ready = (state == rpmc_pkg::FS_IDLE) && !in_valid;
  assign in_ready  = (state == rpmc_pkg::FS_IDLE);
  assign out_valid = (state == rpmc_pkg::FS_OUT);

  logic entry_ok;
  assign entry_ok = {1'b0, entry_r} < 7'(active);

  rpmc_tag_store #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS)) u_tags (
    .clk, .rst,
    .clear      (state == rpmc_pkg::FS_CLEAR && clr_idx == '0),
    .scan_start (state == rpmc_pkg::FS_IDLE && in_valid && !direct_map &&
                 operation == rpmc_pkg::OP_ACQUIRE),
    .key        (page_r),
    .active     (active),
    .wr_en      (wr_tag),
    .wr_slot    (free_head),
    .wr_page    (page_r),
    .rd_slot    (free_head),
    .rd_page    (tag_q),
    .rd_valid   (tag_v),
    .scan_done  (scan_done),
    .hit        (hit),
    .hit_slot   (hit_slot)
  );

  always_comb begin
    state_next = state;
    case (state)
      rpmc_pkg::FS_CLEAR: if (clr_idx == (SW+1)'(SLOTS - 1)) state_next = rpmc_pkg::FS_IDLE;
      rpmc_pkg::FS_IDLE: begin
        if (cfg_valid && cfg_ready && cfg_index == rpmc_pkg::CFG_POOL_SIZE) begin
          state_next = rpmc_pkg::FS_CLEAR;
        end else if (in_valid) begin
          if (direct_map) state_next = rpmc_pkg::FS_OUT;
          else if (operation == rpmc_pkg::OP_ACQUIRE) state_next = rpmc_pkg::FS_SCAN;
          else state_next = rpmc_pkg::FS_READ;
        end
      end
      rpmc_pkg::FS_SCAN: if (scan_done) state_next = rpmc_pkg::FS_READ;
      rpmc_pkg::FS_READ: state_next = rpmc_pkg::FS_EXEC;
      rpmc_pkg::FS_EXEC: state_next = rpmc_pkg::FS_OUT;
      rpmc_pkg::FS_OUT:  if (out_ready) state_next = rpmc_pkg::FS_IDLE;
      default: state_next = rpmc_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    if (op_r == rpmc_pkg::OP_ACQUIRE) tgt = hit ? hit_slot : free_head;
    else tgt = SW'(entry_r);
  end

  always_ff @(posedge clk) begin
    if (state == rpmc_pkg::FS_READ) begin
      rc_q <= refs[tgt];
      nx_q <= fnext[tgt];
      pv_q <= fprev[tgt];
    end
  end

  // list edits: at most one next write and one prev write per item
  logic              wn_en, wp_en, wr_en_r;
  logic [SW-1:0]     wn_a, wn_d, wp_a, wp_d, wr_a;
  logic [REF_BITS-1:0] wr_d;

  always_ff @(posedge clk) begin
    if (state == rpmc_pkg::FS_CLEAR) begin
      refs[clr_idx[SW-1:0]]  <= '0;
      fnext[clr_idx[SW-1:0]] <= clr_idx[SW-1:0] + 1'b1;
      fprev[clr_idx[SW-1:0]] <= clr_idx[SW-1:0] - 1'b1;
    end else begin
      if (wr_en_r) refs[wr_a] <= wr_d;
      if (wn_en) fnext[wn_a] <= wn_d;
      if (wp_en) fprev[wp_a] <= wp_d;
    end
  end

  always_comb begin
    wn_en = 1'b0; wp_en = 1'b0; wr_en_r = 1'b0; wr_tag = 1'b0;
    wn_a = tgt; wn_d = tgt; wp_a = tgt; wp_d = tgt; wr_a = tgt; wr_d = rc_q;
    miss_r = 1'b0;
    if (state == rpmc_pkg::FS_EXEC) begin
      if (op_r == rpmc_pkg::OP_ACQUIRE) begin
        if (hit) begin
          if (rc_q != REF_MAX) begin
            wr_en_r = 1'b1; wr_d = rc_q + 1'b1;
            if (rc_q == '0 && free_count > (SW+1)'(1) && tgt != free_head &&
                tgt != free_tail) begin
              wn_en = 1'b1; wn_a = pv_q; wn_d = nx_q;
              wp_en = 1'b1; wp_a = nx_q; wp_d = pv_q;
            end
          end
        end else if (free_count != '0) begin
          miss_r = 1'b1; wr_tag = 1'b1;
          wr_en_r = 1'b1; wr_d = REF_BITS'(1);
        end
      end else if (op_r == rpmc_pkg::OP_RELEASE && entry_ok && rc_q != '0) begin
        wr_en_r = 1'b1; wr_d = rc_q - 1'b1;
        if (rc_q == REF_BITS'(1) && free_count != '0) begin
          wn_en = 1'b1; wn_a = free_tail; wn_d = tgt;
          wp_en = 1'b1; wp_a = tgt; wp_d = free_tail;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rpmc_pkg::FS_IDLE && in_valid) begin
      op_r <= operation; page_r <= page_index; entry_r <= entry_index; wait_r <= may_wait;
    end
    if (state == rpmc_pkg::FS_IDLE) begin
      o_status <= rpmc_pkg::ST_BYPASS;
      o_slot <= '0; o_rv <= 1'b0; o_rp <= '0; o_refs <= '0; o_wake <= 1'b0;
    end
    if (state == rpmc_pkg::FS_EXEC) begin
      o_slot <= '0; o_rv <= 1'b0; o_rp <= '0; o_refs <= '0; o_wake <= 1'b0;
      o_status <= rpmc_pkg::ST_ERROR;
      case (op_r)
        rpmc_pkg::OP_ACQUIRE: begin
          if (hit) begin
            o_slot <= 6'(tgt);
            if (rc_q == REF_MAX) begin
              o_refs <= rc_q;
            end else begin
              o_refs <= rc_q + 1'b1;
              o_status <= (rc_q == '0) ? rpmc_pkg::ST_HIT_REACT : rpmc_pkg::ST_HIT_IN_USE;
            end
          end else if (free_count == '0) begin
            o_status <= wait_r ? rpmc_pkg::ST_MUST_WAIT : rpmc_pkg::ST_NONE_FREE;
          end else begin
            o_status <= rpmc_pkg::ST_NEW_MAP;
            o_slot <= 6'(tgt); o_refs <= REF_BITS'(1);
            o_rv <= tag_v; o_rp <= tag_v ? tag_q : '0;
          end
        end
        rpmc_pkg::OP_RELEASE: begin
          o_slot <= entry_r;
          if (entry_ok && rc_q != '0) begin
            o_refs <= rc_q - 1'b1;
            if (rc_q == REF_BITS'(1)) begin
              o_status <= rpmc_pkg::ST_FREED;
              o_wake <= waiters != '0;
            end else begin
              o_status <= rpmc_pkg::ST_HELD;
            end
          end
        end
        rpmc_pkg::OP_WAIT_END: o_status <= rpmc_pkg::ST_WAIT_ENDED;
        default: o_status <= rpmc_pkg::ST_ERROR;
      endcase
    end
  end

  logic        remove, append;
  assign remove = (state == rpmc_pkg::FS_EXEC) && op_r == rpmc_pkg::OP_ACQUIRE &&
                  (miss_r || (hit && rc_q == '0));
  assign append = (state == rpmc_pkg::FS_EXEC) && op_r == rpmc_pkg::OP_RELEASE &&
                  entry_ok && rc_q == REF_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpmc_pkg::FS_CLEAR;
      direct_map <= 1'b0;
      pool_size <= 7'(SLOTS > 64 ? 64 : SLOTS);
      clr_idx <= '0;
      free_head <= '0; free_tail <= '0; free_count <= '0;
      in_use <= '0; peak <= '0; waiters <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rpmc_pkg::CFG_DIRECT_MAP) direct_map <= cfg_data[0];
        else pool_size <= cfg_data;
      end
      if (state == rpmc_pkg::FS_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
        free_head <= '0;
        free_tail <= SW'(active - 1'b1);
        free_count <= active;
        in_use <= '0; peak <= '0; waiters <= '0;
      end else begin
        clr_idx <= '0;
      end
      if (remove && free_count != '0) begin
        if (free_count != (SW+1)'(1)) begin
          if (tgt == free_head) free_head <= nx_q;
          else if (tgt == free_tail) free_tail <= pv_q;
        end
        free_count <= free_count - 1'b1;
      end
      if (remove) begin
        in_use <= in_use + 1'b1;
        if (in_use + 1'b1 > peak) peak <= in_use + 1'b1;
      end
      if (append) begin
        if (free_count == '0) free_head <= tgt;
        free_tail <= tgt;
        free_count <= free_count + 1'b1;
        if (in_use != '0) in_use <= in_use - 1'b1;
      end
      if (state == rpmc_pkg::FS_EXEC) begin
        if (op_r == rpmc_pkg::OP_ACQUIRE && !hit && free_count == '0 && wait_r &&
            waiters != 8'(rpmc_pkg::WAITER_MAX)) waiters <= waiters + 1'b1;
        if (op_r == rpmc_pkg::OP_WAIT_END && waiters != '0) waiters <= waiters - 1'b1;
      end
    end
  end

  assign status         = o_status;
  assign slot           = o_slot;
  assign replaced_valid = o_rv;
  assign replaced_page  = o_rp;
  assign refs_now       = o_refs;
  assign wake_waiters   = o_wake;
  assign used_now       = in_use;
  assign used_peak      = peak;

endmodule

// ===== sv/rpmc_tag_store.sv =====
module rpmc_tag_store #(
  parameter int SLOTS     = rpmc_pkg::SLOTS_DEF,
  parameter int PAGE_BITS = rpmc_pkg::PAGE_BITS_DEF,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 scan_start,
  input  logic [PAGE_BITS-1:0] key,
  input  logic [SW:0]          active,
  input  logic                 wr_en,
  input  logic [SW-1:0]        wr_slot,
  input  logic [PAGE_BITS-1:0] wr_page,
  input  logic [SW-1:0]        rd_slot,
  output logic [PAGE_BITS-1:0] rd_page,
  output logic                 rd_valid,
  output logic                 scan_done,
  output logic                 hit,
  output logic [SW-1:0]        hit_slot
);

  logic [PAGE_BITS-1:0] tags [SLOTS];
  logic [SLOTS-1:0]     valid;
  logic [SW:0]          idx;
  logic                 busy;
  logic [PAGE_BITS-1:0] probe;
  logic                 probe_v;
  logic [SW-1:0]        probe_slot;
  logic                 probe_live;
  logic [SW-1:0]        raddr;

  assign raddr = busy ? idx[SW-1:0] : rd_slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tags[wr_slot] <= wr_page;
    end
    probe <= tags[raddr];
  end

  assign rd_page  = probe;
  assign rd_valid = probe_v;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid      <= '0;
      busy       <= 1'b0;
      idx        <= '0;
      probe_live <= 1'b0;
      probe_v    <= 1'b0;
      probe_slot <= '0;
      hit        <= 1'b0;
      hit_slot   <= '0;
      scan_done  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_slot] <= 1'b1;
      end
      probe_v    <= valid[raddr] && !(wr_en && wr_slot == raddr);
      probe_slot <= raddr;
      probe_live <= busy;
      scan_done  <= 1'b0;
      if (scan_start) begin
        busy <= 1'b1;
        idx  <= '0;
        hit  <= 1'b0;
      end else if (busy) begin
        if (idx + 1'b1 >= active) begin
          busy <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
      if (probe_live && probe_v && probe == key && !hit) begin
        hit      <= 1'b1;
        hit_slot <= probe_slot;
      end
      if (probe_live && !busy) begin
        scan_done <= 1'b1;
      end
    end
  end

endmodule

// ===== tb/rpmc_checker.sv =====
module rpmc_checker
  import rpmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [35:0] page_index,
  input  logic [5:0]  entry_index,
  input  logic        may_wait,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  status,
  input  logic [5:0]  slot,
  input  logic        replaced_valid,
  input  logic [35:0] replaced_page,
  input  logic [15:0] refs_now,
  input  logic        wake_waiters,
  input  logic [6:0]  used_now,
  input  logic [6:0]  used_peak,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int NSLOT = 64;
  localparam logic [15:0] REF_LIMIT = 16'hFFFF;

  typedef struct packed {
    status_t     st;
    logic [5:0]  slot;
    logic        rvalid;
    logic [35:0] rpage;
    logic [15:0] refs;
    logic        wake;
    logic [6:0]  used;
    logic [6:0]  peak;
  } map_result_t;

  map_result_t expected_results[$];

  logic        direct_mode;
  logic [6:0]  pool_cfg;
  logic [35:0] tags [NSLOT];
  logic        tag_ok [NSLOT];
  logic [15:0] refs [NSLOT];
  int          nxt [NSLOT];
  int          prv [NSLOT];
  int          head, tail, free_cnt, used_cnt, peak_cnt, waiters;

  function automatic int pool_slots();
    if (pool_cfg == 0) return 1;
    if (pool_cfg > NSLOT) return NSLOT;
    return pool_cfg;
  endfunction

  task automatic rebuild_pool();
    for (int i = 0; i < NSLOT; i++) begin
      tags[i] = '0;
      tag_ok[i] = 1'b0;
      refs[i] = '0;
      nxt[i] = (i + 1) % NSLOT;
      prv[i] = (i + NSLOT - 1) % NSLOT;
    end
    head = 0;
    tail = pool_slots() - 1;
    free_cnt = pool_slots();
    used_cnt = 0;
    peak_cnt = 0;
    waiters = 0;
  endtask

  task automatic unlink_free(int s);
    if (free_cnt == 0) return;
    if (free_cnt == 1) begin
      free_cnt = 0;
      return;
    end
    if (s == head) head = nxt[s];
    else if (s == tail) tail = prv[s];
    else begin
      nxt[prv[s]] = nxt[s];
      prv[nxt[s]] = prv[s];
    end
    free_cnt--;
  endtask

  task automatic link_free(int s);
    if (free_cnt == 0) begin
      head = s;
      tail = s;
    end else begin
      nxt[tail] = s;
      prv[s] = tail;
      tail = s;
    end
    free_cnt++;
  endtask

  task automatic mark_used();
    used_cnt++;
    if (used_cnt > peak_cnt) peak_cnt = used_cnt;
  endtask

  task automatic serve_request(input logic [1:0] op, input logic [35:0] page,
                               input logic [5:0] entry, input logic mw,
                               output map_result_t r);
    int n;
    int hit;
    int s;
    n = pool_slots();
    hit = -1;
    r = '0;
    r.st = ST_ERROR;
    if (direct_mode) begin
      r.st = ST_BYPASS;
    end else if (op == OP_ACQUIRE) begin
      for (int i = 0; i < n; i++)
        if (hit < 0 && tag_ok[i] && tags[i] == page) hit = i;
      if (hit >= 0) begin
        r.slot = 6'(hit);
        if (refs[hit] != REF_LIMIT) begin
          if (refs[hit] == 0) begin
            unlink_free(hit);
            mark_used();
            r.st = ST_HIT_REACT;
          end else begin
            r.st = ST_HIT_IN_USE;
          end
          refs[hit]++;
        end
        r.refs = refs[hit];
      end else if (free_cnt == 0) begin
        if (mw) begin
          if (waiters < WAITER_MAX) waiters++;
          r.st = ST_MUST_WAIT;
        end else begin
          r.st = ST_NONE_FREE;
        end
      end else begin
        s = head;
        unlink_free(s);
        if (tag_ok[s]) begin
          r.rvalid = 1'b1;
          r.rpage = tags[s];
        end
        tags[s] = page;
        tag_ok[s] = 1'b1;
        refs[s] = 16'd1;
        mark_used();
        r.st = ST_NEW_MAP;
        r.slot = 6'(s);
        r.refs = 16'd1;
      end
    end else if (op == OP_RELEASE) begin
      r.slot = entry;
      if (entry < n && refs[entry] != 0) begin
        refs[entry]--;
        r.refs = refs[entry];
        if (refs[entry] == 0) begin
          link_free(entry);
          if (used_cnt > 0) used_cnt--;
          r.wake = waiters > 0;
          r.st = ST_FREED;
        end else begin
          r.st = ST_HELD;
        end
      end
    end else if (op == OP_WAIT_END) begin
      if (waiters > 0) waiters--;
      r.st = ST_WAIT_ENDED;
    end
    r.used = 7'(used_cnt);
    r.peak = 7'(peak_cnt);
  endtask

  always @(posedge clk) begin
    map_result_t got, want;
    if (rst) begin
      direct_mode = 1'b0;
      pool_cfg = 7'd64;
      rebuild_pool();
      expected_results.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status_t'(status), slot, replaced_valid, replaced_page, refs_now,
               wake_waiters, used_now, used_peak};
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result item: %p", got);
        end else begin
          want = expected_results.pop_front();
          checked <= checked + 1;
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10) $display("result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DIRECT_MAP) direct_mode = cfg_data[0];
        else begin
          pool_cfg = cfg_data;
          rebuild_pool();
        end
      end
      if (in_valid && in_ready) begin
        serve_request(operation, page_index, entry_index, may_wait, want);
        expected_results.push_back(want);
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import rpmc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [6:0]  cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  operation;
  logic [35:0] page_index;
  logic [5:0]  entry_index;
  logic        may_wait;
  logic        out_valid, out_ready;
  logic [3:0]  status;
  logic [5:0]  slot;
  logic        replaced_valid;
  logic [35:0] replaced_page;
  logic [15:0] refs_now;
  logic        wake_waiters;
  logic [6:0]  used_now, used_peak;
  int          errors, pending, checked;
  logic        quiet = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;
  int          pool_n = 64;
  logic [35:0] hot_pages [12];

  always #5 clk = ~clk;

  refcounted_page_map_cache u_top (.*);

  rpmc_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      stall_left <= 400;
      hold_done <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input op_t op, input logic [35:0] page,
                           input logic [5:0] entry, input logic mw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    page_index <= page;
    entry_index <= entry;
    may_wait <= mw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_POOL_SIZE) pool_n = value == 0 ? 1 : (value > 64 ? 64 : value);
  endtask

  task automatic random_items(input int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48)
        send_item(OP_ACQUIRE, pick < 40 ? hot_pages[$urandom_range(0, 11)]
                  : 36'({$urandom, $urandom}), 6'd0, 1'($urandom_range(0, 1)));
      else if (pick < 88)
        send_item(OP_RELEASE, 36'({$urandom, $urandom}),
                  pick < 84 ? 6'($urandom_range(0, pool_n - 1)) : 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)));
      else if (pick < 96)
        send_item(OP_WAIT_END, 36'({$urandom, $urandom}), 6'($urandom),
                  1'($urandom_range(0, 1)));
      else
        send_item(OP_BAD, 36'({$urandom, $urandom}), 6'($urandom),
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DIRECT_MAP;
    cfg_data <= '0;
    operation <= OP_ACQUIRE;
    page_index <= '0;
    entry_index <= '0;
    may_wait <= 1'b0;
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    for (int i = 2; i < 12; i++) hot_pages[i] = 36'({$urandom, $urandom});
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_ACQUIRE, 36'd0, 6'd0, 1'b0);
    send_item(OP_ACQUIRE, '1, 6'd63, 1'b1);
    send_item(OP_ACQUIRE, 36'd0, 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd63, 1'b0);
    send_item(OP_ACQUIRE, 36'd0, 6'd0, 1'b0);
    send_item(OP_WAIT_END, 36'd0, 6'd0, 1'b0);
    send_item(OP_BAD, '1, '1, 1'b1);
    send_item(OP_ACQUIRE, hot_pages[2], 6'd0, 1'b0);

    write_reg(CFG_DIRECT_MAP, 7'd1);
    send_item(OP_ACQUIRE, hot_pages[3], 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd0, 1'b0);
    send_item(OP_BAD, 36'd0, 6'd0, 1'b0);
    write_reg(CFG_DIRECT_MAP, 7'd0);

    write_reg(CFG_POOL_SIZE, 7'd0);
    send_item(OP_ACQUIRE, hot_pages[4], 6'd0, 1'b0);
    send_item(OP_ACQUIRE, hot_pages[5], 6'd0, 1'b0);
    send_item(OP_ACQUIRE, hot_pages[5], 6'd0, 1'b1);
    send_item(OP_ACQUIRE, hot_pages[6], 6'd0, 1'b1);
    send_item(OP_WAIT_END, 36'd0, 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd5, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd0, 1'b0);
    send_item(OP_ACQUIRE, hot_pages[5], 6'd0, 1'b0);

    quiet <= 1'b1;
    for (int k = 0; k < 260; k++) send_item(OP_ACQUIRE, hot_pages[7], 6'd0, 1'b1);
    for (int k = 0; k < 4; k++) send_item(OP_WAIT_END, 36'd0, 6'd0, 1'b0);
    for (int k = 0; k < 8; k++) send_item(OP_ACQUIRE, hot_pages[5], 6'd0, 1'b0);
    send_item(OP_RELEASE, 36'd0, 6'd0, 1'b0);
    quiet <= 1'b0;

    write_reg(CFG_POOL_SIZE, 7'd127);
    random_items(60);
    write_reg(CFG_POOL_SIZE, 7'd8);
    random_items(40);
    hold_go <= 1'b1;
    random_items(120);
    write_reg(CFG_POOL_SIZE, 7'd3);
    random_items(120);
    write_reg(CFG_POOL_SIZE, 7'd16);
    quiet <= 1'b1;
    random_items(60);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("checked %0d result items across direct-map and pool sizes 64, 1, 64, 8, 3, 16,",
             checked);
    $display("with waiter overflow and a long output stall");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
